FILE: sv/lcd8w_pkg.sv
// Shared types, codes and constants for the 8-bit character LCD write controller.
// No dependencies; imported by the channel interfaces and the top level.
package lcd8w_pkg;

  // Field widths
  localparam int ActionW = 3;
  localparam int ByteW   = 8;
  localparam int RowW    = 3;
  localparam int CountW  = 16;
  localparam int PulseW  = 8;
  localparam int StepW   = 4;
  localparam int CfgIdxW = 3;
  localparam int CfgDatW = 16;

  // Input actions
  typedef enum logic [ActionW-1:0] {
    ACT_TICK   = 3'd0,
    ACT_CMD    = 3'd1,
    ACT_DATA   = 3'd2,
    ACT_CURSOR = 3'd3,
    ACT_INIT   = 3'd4
  } action_t;

  // Configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CFG_PULSE      = 3'd0,
    CFG_SHORT_WAIT = 3'd1,
    CFG_LONG_WAIT  = 3'd2,
    CFG_POWER_ON   = 3'd3,
    CFG_FIRST_WAKE = 3'd4,
    CFG_WAKE       = 3'd5
  } cfg_idx_t;

  // Controller bytes
  localparam logic [ByteW-1:0] CMD_WAKE       = 8'h30;
  localparam logic [ByteW-1:0] CMD_FUNC_SET   = 8'h38;
  localparam logic [ByteW-1:0] CMD_DISP_ON    = 8'h0C;
  localparam logic [ByteW-1:0] CMD_ENTRY_MODE = 8'h06;
  localparam logic [ByteW-1:0] CMD_CLEAR      = 8'h01;
  localparam logic [ByteW-1:0] CMD_HOME       = 8'h02;
  localparam logic [ByteW-1:0] DDRAM_SET      = 8'h80;

  // Init sequence steps
  localparam logic [StepW-1:0] STEP_NONE      = 4'd0;
  localparam logic [StepW-1:0] STEP_POWER     = 4'd1;
  localparam logic [StepW-1:0] STEP_WAKE1     = 4'd2;
  localparam logic [StepW-1:0] STEP_WAKE2     = 4'd3;
  localparam logic [StepW-1:0] STEP_WAKE3     = 4'd4;
  localparam logic [StepW-1:0] STEP_FUNC_SET  = 4'd5;
  localparam logic [StepW-1:0] STEP_DISP_ON   = 4'd6;
  localparam logic [StepW-1:0] STEP_ENTRY     = 4'd7;
  localparam logic [StepW-1:0] STEP_CLEAR     = 4'd8;

  // Register reset values
  localparam logic [PulseW-1:0] RST_PULSE      = 8'd1;
  localparam logic [CountW-1:0] RST_SHORT_WAIT = 16'd100;
  localparam logic [CountW-1:0] RST_LONG_WAIT  = 16'd2000;
  localparam logic [CountW-1:0] RST_POWER_ON   = 16'd20000;
  localparam logic [CountW-1:0] RST_FIRST_WAKE = 16'd5000;
  localparam logic [CountW-1:0] RST_WAKE       = 16'd150;

  // DDRAM base address of a display row; rows past the fourth start at zero
  function automatic logic [ByteW-1:0] row_base(input logic [RowW-1:0] row);
    logic [ByteW-1:0] base;
    unique case (row)
      3'd1:    base = 8'h40;
      3'd2:    base = 8'h14;
      3'd3:    base = 8'h54;
      default: base = 8'h00;
    endcase
    return base;
  endfunction

  // Byte sent at a given init step
  function automatic logic [ByteW-1:0] init_byte(input logic [StepW-1:0] step);
    logic [ByteW-1:0] b;
    unique case (step)
      STEP_FUNC_SET: b = CMD_FUNC_SET;
      STEP_DISP_ON:  b = CMD_DISP_ON;
      STEP_ENTRY:    b = CMD_ENTRY_MODE;
      STEP_CLEAR:    b = CMD_CLEAR;
      default:       b = CMD_WAKE;
    endcase
    return b;
  endfunction

  // A zero timing value counts as one tick
  function automatic logic [CountW-1:0] at_least_one(input logic [CountW-1:0] v);
    return (v == '0) ? CountW'(1) : v;
  endfunction

endpackage

FILE: sv/lcd8w_in_if.sv
// Request/tick channel into the LCD write controller.
// Depends on lcd8w_pkg for field widths.
interface lcd8w_in_if
  import lcd8w_pkg::*;
  ();
  logic                 valid;
  logic                 ready;
  logic [ActionW-1:0]   action;
  logic [ByteW-1:0]     byte_value;
  logic [ByteW-1:0]     column;
  logic [RowW-1:0]      row;

  modport source (output valid, action, byte_value, column, row, input ready);
  modport sink   (input valid, action, byte_value, column, row, output ready);
endinterface

FILE: sv/lcd8w_out_if.sv
// Result channel out of the LCD write controller: pin levels and status per beat.
// Depends on lcd8w_pkg for field widths.
interface lcd8w_out_if
  import lcd8w_pkg::*;
  ();
  logic             valid;
  logic             ready;
  logic             reg_select;
  logic             enable_pin;
  logic [ByteW-1:0] bus_byte;
  logic             busy_res;
  logic             accepted;

  modport source (output valid, reg_select, enable_pin, bus_byte, busy_res, accepted,
                  input ready);
  modport sink   (input valid, reg_select, enable_pin, bus_byte, busy_res, accepted,
                  output ready);
endinterface

FILE: sv/lcd8w_cfg_if.sv
// Configuration write channel of the LCD write controller.
// Depends on lcd8w_pkg for index and data widths.
interface lcd8w_cfg_if
  import lcd8w_pkg::*;
  ();
  logic               valid;
  logic               ready;
  logic [CfgIdxW-1:0] index;
  logic [CfgDatW-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

FILE: sv/char_lcd_8bit_write_controller.sv
// Top level of the 8-bit character LCD write controller.
// Depends on lcd8w_pkg and the lcd8w_in_if, lcd8w_out_if and lcd8w_cfg_if interfaces.
//
// Usage:
//   in_ch carries one beat per microsecond tick (action tick) or per request
//   (command, data, cursor position, init). Each input beat yields exactly one
//   out_ch beat with the RS, EN and bus pin levels after the beat is applied,
//   a busy flag and whether the request was taken (requests while busy are
//   dropped with accepted low). cfg_ch writes the six timing registers; it is
//   always ready and should only be used while the block is idle.
// Timing:
//   An accepted beat lands in an input register; when the result register is empty
//   or being taken, the beat is applied to the pin/timer state and its result is
//   loaded into the output register at that same edge: one beat per cycle sustained
//   while out_ch is not stalled. The throughput is set by the single state update
//   between the input and result registers.
// Reset and stalls:
//   rst_n (synchronous, active low) idles the pins, clears the timers and loads
//   the default timing values. When out_ch stalls, the input register still
//   takes one more beat, then in_ch.ready drops until the result is taken.
module char_lcd_8bit_write_controller
  import lcd8w_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  lcd8w_in_if.sink    in_ch,
  lcd8w_out_if.source out_ch,
  lcd8w_cfg_if.sink   cfg_ch
);

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_PULSE = 2'd1,
    PH_WAIT  = 2'd2,
    PH_POWER = 2'd3
  } phase_t;

  // Timing registers
  logic [PulseW-1:0] pulse_ticks_r;
  logic [CountW-1:0] short_wait_r, long_wait_r, power_on_r, first_wake_r, wake_r;

  // Input register
  logic               in_valid_r;
  logic [ActionW-1:0] action_r;
  logic [ByteW-1:0]   byte_r, column_r;
  logic [RowW-1:0]    row_r;

  // Controller state
  phase_t            phase_r, phase_nxt;
  logic [CountW-1:0] count_r, count_nxt;
  logic [StepW-1:0]  step_r, step_nxt;
  logic              long_r, long_nxt;
  logic              rs_r, rs_nxt;
  logic              en_r, en_nxt;
  logic [ByteW-1:0]  bus_r, bus_nxt;
  logic              taken;

  // Result register
  logic             out_valid_r;
  logic             out_rs_r, out_en_r, out_busy_r, out_acc_r;
  logic [ByteW-1:0] out_bus_r;

  logic advance;
  logic [CountW-1:0] count_dec;
  logic [CountW-1:0] wait_sel;
  logic [ByteW-1:0]  cmd_byte;
  logic [ByteW-1:0]  step_byte;
  logic [StepW-1:0]  step_inc;

  assign advance      = in_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready  = !in_valid_r || advance;
  assign cfg_ch.ready = 1'b1;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pulse_ticks_r <= RST_PULSE;
      short_wait_r  <= RST_SHORT_WAIT;
      long_wait_r   <= RST_LONG_WAIT;
      power_on_r    <= RST_POWER_ON;
      first_wake_r  <= RST_FIRST_WAKE;
      wake_r        <= RST_WAKE;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        CFG_PULSE:      pulse_ticks_r <= cfg_ch.data[PulseW-1:0];
        CFG_SHORT_WAIT: short_wait_r  <= cfg_ch.data;
        CFG_LONG_WAIT:  long_wait_r   <= cfg_ch.data;
        CFG_POWER_ON:   power_on_r    <= cfg_ch.data;
        CFG_FIRST_WAKE: first_wake_r  <= cfg_ch.data;
        CFG_WAKE:       wake_r        <= cfg_ch.data;
        default: ;
      endcase
    end
  end

  // Input register: takes a beat whenever it is empty or draining
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      in_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      action_r <= in_ch.action;
      byte_r   <= in_ch.byte_value;
      column_r <= in_ch.column;
      row_r    <= in_ch.row;
    end
  end

  // Wait length once EN falls
  always_comb begin
    if (step_r != STEP_NONE) begin
      unique case (step_r)
        STEP_WAKE1:             wait_sel = first_wake_r;
        STEP_WAKE2, STEP_WAKE3: wait_sel = wake_r;
        STEP_CLEAR:             wait_sel = long_wait_r;
        default:                wait_sel = short_wait_r;
      endcase
    end else begin
      wait_sel = long_r ? long_wait_r : short_wait_r;
    end
  end

  assign count_dec = count_r - CountW'(1);
  assign step_inc  = step_r + StepW'(1);
  assign step_byte = init_byte(step_inc);
  assign cmd_byte  = (action_r == ACT_CURSOR) ?
                     ((row_base(row_r) + column_r) | DDRAM_SET) : byte_r;

  // Next state for the beat in the input register
  always_comb begin
    phase_nxt = phase_r;
    count_nxt = count_r;
    step_nxt  = step_r;
    long_nxt  = long_r;
    rs_nxt    = rs_r;
    en_nxt    = en_r;
    bus_nxt   = bus_r;
    taken     = 1'b0;

    if (action_r == ACT_TICK) begin
      if (phase_r != PH_IDLE) begin
        if (count_dec != '0) begin
          count_nxt = count_dec;
        end else begin
          unique case (phase_r)
            PH_PULSE: begin
              en_nxt    = 1'b0;
              phase_nxt = PH_WAIT;
              count_nxt = at_least_one(wait_sel);
            end
            PH_POWER: begin
              step_nxt  = STEP_WAKE1;
              long_nxt  = 1'b0;
              rs_nxt    = 1'b0;
              bus_nxt   = CMD_WAKE;
              en_nxt    = 1'b1;
              phase_nxt = PH_PULSE;
              count_nxt = at_least_one({{(CountW-PulseW){1'b0}}, pulse_ticks_r});
            end
            default: begin
              // end of a wait: next init write, or back to idle
              if (step_r >= STEP_WAKE1 && step_r < STEP_CLEAR) begin
                step_nxt  = step_inc;
                long_nxt  = (step_byte == CMD_CLEAR) || (step_byte == CMD_HOME);
                rs_nxt    = 1'b0;
                bus_nxt   = step_byte;
                en_nxt    = 1'b1;
                phase_nxt = PH_PULSE;
                count_nxt = at_least_one({{(CountW-PulseW){1'b0}}, pulse_ticks_r});
              end else begin
                step_nxt  = STEP_NONE;
                phase_nxt = PH_IDLE;
              end
            end
          endcase
        end
      end
    end else if (action_r <= ACT_INIT && phase_r == PH_IDLE) begin
      taken = 1'b1;
      if (action_r == ACT_INIT) begin
        rs_nxt    = 1'b0;
        en_nxt    = 1'b0;
        long_nxt  = 1'b0;
        step_nxt  = STEP_POWER;
        phase_nxt = PH_POWER;
        count_nxt = at_least_one(power_on_r);
      end else begin
        // command, data or cursor write
        rs_nxt    = (action_r == ACT_DATA);
        bus_nxt   = cmd_byte;
        long_nxt  = (action_r != ACT_DATA) &&
                    ((cmd_byte == CMD_CLEAR) || (cmd_byte == CMD_HOME));
        en_nxt    = 1'b1;
        phase_nxt = PH_PULSE;
        count_nxt = at_least_one({{(CountW-PulseW){1'b0}}, pulse_ticks_r});
      end
    end
  end

  // Controller state and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      count_r     <= '0;
      step_r      <= STEP_NONE;
      long_r      <= 1'b0;
      rs_r        <= 1'b0;
      en_r        <= 1'b0;
      bus_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (advance) begin
        phase_r     <= phase_nxt;
        count_r     <= count_nxt;
        step_r      <= step_nxt;
        long_r      <= long_nxt;
        rs_r        <= rs_nxt;
        en_r        <= en_nxt;
        bus_r       <= bus_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_rs_r   <= rs_nxt;
      out_en_r   <= en_nxt;
      out_bus_r  <= bus_nxt;
      out_busy_r <= (phase_nxt != PH_IDLE);
      out_acc_r  <= taken;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.reg_select = out_rs_r;
  assign out_ch.enable_pin = out_en_r;
  assign out_ch.bus_byte   = out_bus_r;
  assign out_ch.busy_res   = out_busy_r;
  assign out_ch.accepted   = out_acc_r;

endmodule
